// File: sv/bech32_address_encoder_defines.svh
// Assertion helpers for the bech32 encoder.
// Expect i_clk and i_rst_n in the enclosing module.
`ifndef BECH32_ADDRESS_ENCODER_DEFINES_SVH
`define BECH32_ADDRESS_ENCODER_DEFINES_SVH

`ifndef SYNTH
`define B32_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("b32 same-cycle check failed");
`define B32_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("b32 next-cycle check failed");
`else
`define B32_ASSERT_IMPL(lbl, ante, cons)
`define B32_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: sv/b32_pkg.sv
package b32_pkg;

    localparam int unsigned ChkW  = 30;
    localparam int unsigned SymW  = 5;
    localparam int unsigned ByteW = 8;
    localparam int unsigned CharW = 7;

    localparam logic [ChkW-1:0] SeedReset = 30'd1;

    // BIP173 generator terms, one per top bit of the state
    localparam logic [ChkW-1:0] Gen0 = 30'h3b6a57b2;
    localparam logic [ChkW-1:0] Gen1 = 30'h26508e6d;
    localparam logic [ChkW-1:0] Gen2 = 30'h1ea119fa;
    localparam logic [ChkW-1:0] Gen3 = 30'h3d4233dd;
    localparam logic [ChkW-1:0] Gen4 = 30'h2a1462b3;

    // bech32 alphabet: qpzry9x8gf2tvdw0s3jn54khce6mua7l
    function automatic logic [CharW-1:0] sym_to_char(input logic [SymW-1:0] sym);
        logic [CharW-1:0] c;
        unique case (sym)
            5'd0:  c = 7'h71;  5'd1:  c = 7'h70;  5'd2:  c = 7'h7a;  5'd3:  c = 7'h72;
            5'd4:  c = 7'h79;  5'd5:  c = 7'h39;  5'd6:  c = 7'h78;  5'd7:  c = 7'h38;
            5'd8:  c = 7'h67;  5'd9:  c = 7'h66;  5'd10: c = 7'h32;  5'd11: c = 7'h74;
            5'd12: c = 7'h76;  5'd13: c = 7'h64;  5'd14: c = 7'h77;  5'd15: c = 7'h30;
            5'd16: c = 7'h73;  5'd17: c = 7'h33;  5'd18: c = 7'h6a;  5'd19: c = 7'h6e;
            5'd20: c = 7'h35;  5'd21: c = 7'h34;  5'd22: c = 7'h6b;  5'd23: c = 7'h68;
            5'd24: c = 7'h63;  5'd25: c = 7'h65;  5'd26: c = 7'h36;  5'd27: c = 7'h6d;
            5'd28: c = 7'h75;  5'd29: c = 7'h61;  5'd30: c = 7'h37;  5'd31: c = 7'h6c;
            default: c = 7'h71;
        endcase
        return c;
    endfunction

endpackage

// File: sv/b32_if.sv
interface b32_byte_if;
    logic                          valid;
    logic                          ready;
    logic [b32_pkg::ByteW-1:0]     data_byte;
    logic                          last_byte;
    modport source (output valid, data_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface b32_char_if;
    logic                          valid;
    logic                          ready;
    logic [b32_pkg::CharW-1:0]     char_code;
    logic                          is_checksum;
    logic                          last_char;
    modport source (output valid, char_code, is_checksum, last_char, input ready);
    modport sink   (input valid, char_code, is_checksum, last_char, output ready);
endinterface

interface b32_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [b32_pkg::ChkW-1:0]      prefix_seed;
    modport source (output valid, prefix_seed, input ready);
    modport sink   (input valid, prefix_seed, output ready);
endinterface

// File: sv/b32_polymod.sv
// One polymod step: shift in a symbol, fold the five top bits back in.
module b32_polymod (
    input  logic [b32_pkg::ChkW-1:0] i_chk,
    input  logic [b32_pkg::SymW-1:0] i_sym,
    output logic [b32_pkg::ChkW-1:0] o_chk
);

    logic [b32_pkg::SymW-1:0] top;
    logic [b32_pkg::ChkW-1:0] base;

    always_comb begin
        top   = i_chk[29:25];
        base  = {i_chk[24:0], i_sym};
        o_chk = base
              ^ (top[0] ? b32_pkg::Gen0 : '0)
              ^ (top[1] ? b32_pkg::Gen1 : '0)
              ^ (top[2] ? b32_pkg::Gen2 : '0)
              ^ (top[3] ? b32_pkg::Gen3 : '0)
              ^ (top[4] ? b32_pkg::Gen4 : '0);
    end

endmodule

// File: sv/bech32_address_encoder.sv
// Channel   Dir  Payload                                 Word
// i_byte    in   data_byte[7:0], last_byte                one payload byte
// o_char    out  char_code[6:0], is_checksum, last_char   one address character
// i_cfg     in   prefix_seed[29:0]                        checksum seed, always ready
//
// One polymod unit folds one symbol per cycle under a four-state sequencer.
// A byte is accepted, folded as one or two symbols and then wrapped up; a last byte
// adds an optional pad symbol, six zero folds and six checksum characters.
// A symbol cycle waits while the output register holds a word not yet taken.
// i_byte is held off in any cycle that offers a seed word.
// Synchronous active-low reset: seed 1, empty bit buffer, idle.
`include "bech32_address_encoder_defines.svh"

module bech32_address_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    b32_byte_if.sink    i_byte,
    b32_char_if.source  o_char,
    b32_cfg_if.sink     i_cfg
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DATA = 4'b0010,
        S_ZERO = 4'b0100,
        S_SUM  = 4'b1000
    } t_state;

    t_state                    r_state, n_state;
    logic [b32_pkg::ChkW-1:0]  r_seed, n_seed;
    logic [b32_pkg::ChkW-1:0]  r_chk, n_chk;
    logic [11:0]               r_acc, n_acc;
    logic [3:0]                r_bits, n_bits;
    logic [3:0]                r_buf, n_buf;
    logic [2:0]                r_bit_count, n_bit_count;
    logic                      r_last, n_last;
    logic [2:0]                r_cnt, n_cnt;
    logic                      r_out_valid, n_out_valid;
    logic [b32_pkg::CharW-1:0] r_char_code, n_char_code;
    logic                      r_is_checksum, n_is_checksum;
    logic                      r_last_char, n_last_char;

    logic                      slot_free;
    logic [b32_pkg::SymW-1:0]  fold_sym;
    logic [b32_pkg::ChkW-1:0]  fold_chk;
    logic [3:0]                sh_diff;
    logic [4:0]                keep_mask;
    logic [b32_pkg::SymW-1:0]  data_sym;
    logic [b32_pkg::SymW-1:0]  pad_sym;

    b32_polymod u_polymod (
        .i_chk (r_chk),
        .i_sym (fold_sym),
        .o_chk (fold_chk)
    );

    assign i_byte.ready       = (r_state == S_IDLE) && !i_cfg.valid;
    assign i_cfg.ready        = 1'b1;
    assign o_char.valid       = r_out_valid;
    assign o_char.char_code   = r_char_code;
    assign o_char.is_checksum = r_is_checksum;
    assign o_char.last_char   = r_last_char;

    assign slot_free = !r_out_valid || o_char.ready;

    always_comb begin
        sh_diff   = r_bits - 4'd5;
        data_sym  = 5'(r_acc >> sh_diff[2:0]);
        pad_sym   = 5'(r_acc << (3'd5 - r_bits[2:0]));
        keep_mask = (5'd1 << r_bits[2:0]) - 5'd1;
        fold_sym  = '0;
        if (r_state == S_DATA) begin
            fold_sym = (r_bits >= 4'd5) ? data_sym : pad_sym;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_seed        = r_seed;
        n_chk         = r_chk;
        n_acc         = r_acc;
        n_bits        = r_bits;
        n_buf         = r_buf;
        n_bit_count   = r_bit_count;
        n_last        = r_last;
        n_cnt         = r_cnt;
        n_out_valid   = r_out_valid && !o_char.ready;
        n_char_code   = r_char_code;
        n_is_checksum = r_is_checksum;
        n_last_char   = r_last_char;

        unique case (r_state)
            S_IDLE: begin
                if (i_byte.valid) begin
                    n_acc   = {r_buf, i_byte.data_byte};
                    n_bits  = {1'b0, r_bit_count} + 4'd8;
                    n_last  = i_byte.last_byte;
                    n_state = S_DATA;
                end
            end
            S_DATA: begin
                if (r_bits >= 4'd5) begin
                    if (slot_free) begin
                        n_out_valid   = 1'b1;
                        n_char_code   = b32_pkg::sym_to_char(data_sym);
                        n_is_checksum = 1'b0;
                        n_last_char   = 1'b0;
                        n_chk         = fold_chk;
                        n_bits        = r_bits - 4'd5;
                    end
                end else if (!r_last) begin
                    n_buf       = r_acc[3:0] & keep_mask[3:0];
                    n_bit_count = r_bits[2:0];
                    n_state     = S_IDLE;
                end else if (r_bits != 4'd0) begin
                    // leftover bits, zero-padded on the right
                    if (slot_free) begin
                        n_out_valid   = 1'b1;
                        n_char_code   = b32_pkg::sym_to_char(pad_sym);
                        n_is_checksum = 1'b0;
                        n_last_char   = 1'b0;
                        n_chk         = fold_chk;
                        n_bits        = 4'd0;
                    end
                end else begin
                    n_cnt   = 3'd0;
                    n_state = S_ZERO;
                end
            end
            S_ZERO: begin
                n_chk = fold_chk;
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd5) begin
                    n_chk   = fold_chk ^ 30'd1;
                    n_cnt   = 3'd0;
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                if (slot_free) begin
                    n_out_valid   = 1'b1;
                    n_char_code   = b32_pkg::sym_to_char(r_chk[29:25]);
                    n_is_checksum = 1'b1;
                    n_last_char   = (r_cnt == 3'd5);
                    n_chk         = {r_chk[24:0], 5'd0};
                    n_cnt         = r_cnt + 3'd1;
                    if (r_cnt == 3'd5) begin
                        n_chk       = r_seed;
                        n_buf       = '0;
                        n_bit_count = '0;
                        n_cnt       = 3'd0;
                        n_state     = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // seed write restarts the address
        if (i_cfg.valid) begin
            n_seed      = i_cfg.prefix_seed;
            n_chk       = i_cfg.prefix_seed;
            n_buf       = '0;
            n_bit_count = '0;
            n_cnt       = 3'd0;
            n_state     = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seed      <= b32_pkg::SeedReset;
            r_chk       <= b32_pkg::SeedReset;
            r_buf       <= '0;
            r_bit_count <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seed      <= n_seed;
            r_chk       <= n_chk;
            r_buf       <= n_buf;
            r_bit_count <= n_bit_count;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc         <= n_acc;
        r_bits        <= n_bits;
        r_last        <= n_last;
        r_char_code   <= n_char_code;
        r_is_checksum <= n_is_checksum;
        r_last_char   <= n_last_char;
    end

    `B32_ASSERT_IMPL(a_state_onehot, 1'b1, $onehot(r_state))
    `B32_ASSERT_IMPL(a_count_range, 1'b1, r_bit_count <= 3'd4)
    `B32_ASSERT_IMPL(a_last_is_sum, o_char.valid && o_char.last_char, o_char.is_checksum)
    `B32_ASSERT_NEXT(a_zero_to_sum, r_state == S_ZERO && r_cnt == 3'd5 && !i_cfg.valid,
                     r_state == S_SUM)
    `B32_ASSERT_NEXT(a_sum_emits, r_state == S_SUM && slot_free && !i_cfg.valid,
                     r_out_valid && r_is_checksum)

endmodule

// File: bench/bech32_address_encoder_checker.sv
module bech32_address_encoder_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    b32_byte_if  i_byte,
    b32_char_if  i_char,
    b32_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [b32_pkg::CharW-1:0] code;
        logic                      is_chk;
        logic                      fin;
    } t_addr_char;

    // first character in the top byte
    localparam logic [8*32-1:0] Alphabet = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

    logic [b32_pkg::ChkW-1:0] seed_reg;
    logic [b32_pkg::ChkW-1:0] chk_state;
    logic [3:0]               pend_bits;
    int                       pend_cnt;
    t_addr_char               expected_chars[$];
    int                       char_index;
    int                       fails;

    assign o_fail_count = fails;

    function automatic logic [b32_pkg::ChkW-1:0] polymod_step(
        input logic [b32_pkg::ChkW-1:0] chk,
        input logic [b32_pkg::SymW-1:0] sym);
        logic [4:0]               top;
        logic [b32_pkg::ChkW-1:0] nxt;
        top = chk[29:25];
        nxt = {chk[24:0], 5'd0} ^ {25'd0, sym};
        if (top[0]) nxt ^= b32_pkg::Gen0;
        if (top[1]) nxt ^= b32_pkg::Gen1;
        if (top[2]) nxt ^= b32_pkg::Gen2;
        if (top[3]) nxt ^= b32_pkg::Gen3;
        if (top[4]) nxt ^= b32_pkg::Gen4;
        return nxt;
    endfunction

    task automatic push_char(input logic [b32_pkg::SymW-1:0] sym, input logic is_chk,
                             input logic fin);
        t_addr_char c;
        c.code   = Alphabet[8*(31-int'(sym)) +: b32_pkg::CharW];
        c.is_chk = is_chk;
        c.fin    = fin;
        expected_chars.push_back(c);
    endtask

    task automatic encode_byte(input logic [b32_pkg::ByteW-1:0] data, input logic last);
        logic [11:0]              acc;
        logic [b32_pkg::SymW-1:0] sym;
        int                       nbits;
        int                       i;
        acc   = {pend_bits, data};
        nbits = pend_cnt + 8;
        while (nbits >= 5) begin
            sym = 5'(acc >> (nbits - 5));
            push_char(sym, 1'b0, 1'b0);
            chk_state = polymod_step(chk_state, sym);
            nbits -= 5;
        end
        acc = acc & ((12'd1 << nbits) - 12'd1);
        if (!last) begin
            pend_bits = acc[3:0];
            pend_cnt  = nbits;
        end else begin
            // leftover bits padded with zeros on the right
            if (nbits > 0) begin
                sym = 5'(acc << (5 - nbits));
                push_char(sym, 1'b0, 1'b0);
                chk_state = polymod_step(chk_state, sym);
            end
            for (i = 0; i < 6; i++) chk_state = polymod_step(chk_state, 5'd0);
            chk_state ^= 30'd1;
            for (i = 0; i < 6; i++) begin
                sym = 5'(chk_state >> (5 * (5 - i)));
                push_char(sym, 1'b1, i == 5);
            end
            chk_state = seed_reg;
            pend_bits = '0;
            pend_cnt  = 0;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        fails++;
        $display("char %0d: %s mismatch, got %0h expected %0h", char_index, what, got, want);
    endtask

    task automatic check_char(input logic [b32_pkg::CharW-1:0] code, input logic is_chk,
                              input logic fin);
        t_addr_char want;
        if (expected_chars.size() == 0) begin
            report_mismatch("unexpected word", code, 0);
        end else begin
            want = expected_chars.pop_front();
            if (code !== want.code) report_mismatch("char_code", code, want.code);
            if (is_chk !== want.is_chk) report_mismatch("is_checksum", is_chk, want.is_chk);
            if (fin !== want.fin) report_mismatch("last_char", fin, want.fin);
        end
        char_index++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seed_reg  = b32_pkg::SeedReset;
            chk_state = b32_pkg::SeedReset;
            pend_bits = '0;
            pend_cnt  = 0;
            expected_chars.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                seed_reg  = i_cfg.prefix_seed;
                chk_state = i_cfg.prefix_seed;
                pend_bits = '0;
                pend_cnt  = 0;
            end
            // a word leaving now cannot stem from a byte taken at this edge
            if (i_char.valid && i_char.ready)
                check_char(i_char.char_code, i_char.is_checksum, i_char.last_char);
            if (i_byte.valid && i_byte.ready)
                encode_byte(i_byte.data_byte, i_byte.last_byte);
        end
        o_pending = expected_chars.size();
    end

endmodule

// File: bench/bech32_address_encoder_tb.sv
module bech32_address_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [b32_pkg::ByteW-1:0] t_byte_seq[$];

    localparam int CycleLimit   = 200000;
    localparam int HoldCycles   = 300;
    localparam int SettleCycles = 24;
    localparam int RandomItems  = 220;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending_chars;
    int   items_sent;
    int   burst_left;
    int   tx_gap_max;
    int   rx_stall_pct;
    bit   hold_req;
    int   cycle_count;

    b32_byte_if byte_ch();
    b32_char_if char_ch();
    b32_cfg_if  cfg_ch();

    bech32_address_encoder i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_char  (char_ch),
        .i_cfg   (cfg_ch)
    );

    bech32_address_encoder_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte       (byte_ch),
        .i_char       (char_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_chars)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    initial begin
        cycle_count = 0;
        while (cycle_count < CycleLimit) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // receiver: short random stalls, plus one long hold-off on request
    initial begin
        int  stall_left;
        int  hold_left;
        bit  hold_started;
        stall_left   = 0;
        hold_left    = 0;
        hold_started = 0;
        char_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_started) begin
                hold_started = 1;
                hold_left    = HoldCycles;
            end
            if (hold_left > 0) begin
                hold_left--;
                char_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                char_ch.ready <= 1'b0;
            end else if ($urandom_range(1, 100) <= rx_stall_pct) begin
                stall_left = $urandom_range(0, 7);
                char_ch.ready <= 1'b0;
            end else begin
                char_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [b32_pkg::ByteW-1:0] data, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 10);
            if (tx_gap_max > 0) begin
                gap = $urandom_range(1, tx_gap_max);
                byte_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= data;
        byte_ch.last_byte <= last;
        do @(posedge i_clk); while (!byte_ch.ready);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_message(input t_byte_seq msg, input bit finish);
        int i;
        for (i = 0; i < msg.size(); i++)
            send_byte(msg[i], finish && (i == msg.size() - 1));
    endtask

    task automatic wait_until_drained();
        byte_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending_chars != 0);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic load_seed(input logic [b32_pkg::ChkW-1:0] value);
        wait_until_drained();
        cfg_ch.valid       <= 1'b1;
        cfg_ch.prefix_seed <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [b32_pkg::ChkW-1:0] random_seed();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return {b32_pkg::ChkW{1'b1}};
            default: return b32_pkg::ChkW'($urandom);
        endcase
    endfunction

    initial begin
        t_byte_seq msg;
        int        item_target;
        int        rand_base;
        int        len;
        byte_ch.valid      <= 1'b0;
        byte_ch.data_byte  <= '0;
        byte_ch.last_byte  <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.prefix_seed <= '0;
        i_rst_n            <= 1'b0;
        items_sent   = 0;
        burst_left   = 0;
        tx_gap_max   = 3;
        rx_stall_pct = 25;
        hold_req     = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // lengths 1..5 leave 3, 1, 4, 2 and 0 bits for the pad word
        msg = {8'h00};
        send_message(msg, 1);
        msg = {8'hff, 8'h80};
        send_message(msg, 1);
        load_seed('0);
        msg = {8'ha5, 8'h5a, 8'h01};
        send_message(msg, 1);
        load_seed({b32_pkg::ChkW{1'b1}});
        msg = {8'hff, 8'hff, 8'hff, 8'hff};
        send_message(msg, 1);
        msg = {8'h00, 8'hff, 8'ha5, 8'h5a, 8'hc3};
        send_message(msg, 1);
        // seed reload mid-address drops the buffered bits
        msg = {8'h81};
        send_message(msg, 0);
        load_seed(30'h2aaaaaaa);
        msg = {8'h7e};
        send_message(msg, 1);

        rand_base   = items_sent;
        item_target = items_sent + RandomItems;
        while (items_sent < item_target) begin
            if (items_sent < rand_base + 60) begin
                tx_gap_max   = 0;
                rx_stall_pct = 0;
            end else begin
                tx_gap_max   = $urandom_range(1, 8);
                rx_stall_pct = $urandom_range(0, 60);
            end
            if ($urandom_range(0, 9) == 0) len = $urandom_range(13, 40);
            else len = $urandom_range(1, 12);
            // long address pushed at full rate into a stalled output
            if (!hold_req && items_sent >= rand_base + 100) begin
                hold_req   = 1;
                tx_gap_max = 0;
                len        = 30;
            end
            msg.delete();
            repeat (len) msg.push_back(b32_pkg::ByteW'($urandom));
            if ($urandom_range(0, 9) == 0) begin
                send_message(msg, 0);
                load_seed(random_seed());
            end else begin
                send_message(msg, 1);
                if ($urandom_range(0, 4) == 0) load_seed(random_seed());
            end
        end
        wait_until_drained();

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: bech32_address_encoder.f
+incdir+sv
sv/b32_pkg.sv
sv/b32_if.sv
sv/b32_polymod.sv
sv/bech32_address_encoder.sv
bench/bech32_address_encoder_checker.sv
bench/bech32_address_encoder_tb.sv
